// File: rtl/core/m3asm_pkg.sv
`default_nettype none
package m3asm_pkg;

  // Matrix geometry and element width.
  localparam int DIM        = 3;
  localparam int ELEM_WIDTH = 16;
  localparam int CELLS      = DIM * DIM;

  // Field widths fixed by the port list.
  localparam int OP_W   = 2;
  localparam int ROW_W  = 2;
  localparam int RES_W  = 33;

  // Derived widths.
  localparam int IDX_W  = $clog2(CELLS);
  localparam int CNT_W  = $clog2(2 * CELLS);
  localparam int DIM_W  = $clog2(DIM);
  localparam int SUM_W  = ELEM_WIDTH + 1;
  localparam int PROD_W = 2 * ELEM_WIDTH;

  typedef enum logic [OP_W-1:0] {
    OP_ADD  = 2'd0,
    OP_SUB  = 2'd1,
    OP_MUL  = 2'd2,
    OP_NONE = 2'd3
  } op_t;

  // Memory write port, driven while matrix elements are loaded.
  typedef struct packed {
    logic                  a_we;
    logic                  b_we;
    logic [IDX_W-1:0]      addr;
    logic [ELEM_WIDTH-1:0] data;
  } wr_t;

  // Memory read request, one operand pair per cycle while the pipeline advances.
  typedef struct packed {
    logic             re;
    logic [IDX_W-1:0] a_addr;
    logic [IDX_W-1:0] b_addr;
  } rd_t;

  // Tag that travels with each operand pair through the pipeline.
  typedef struct packed {
    logic             valid;
    op_t              op;
    logic             first;
    logic             last_k;
    logic [DIM_W-1:0] row;
    logic [DIM_W-1:0] col;
    logic             last;
  } tag_t;

endpackage
`default_nettype wire

// File: rtl/core/m3asm_ram.sv
`default_nettype none
module m3asm_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 9
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule
`default_nettype wire

// File: rtl/core/m3asm_seq.sv
`default_nettype none
module m3asm_seq (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire logic                              in_valid,
  output logic                                   in_ready,
  input  wire logic [m3asm_pkg::OP_W-1:0]        op,
  input  wire logic [m3asm_pkg::ELEM_WIDTH-1:0]  value,
  input  wire logic                              advance,
  input  wire logic                              pipe_busy,
  output m3asm_pkg::wr_t                         wr,
  output m3asm_pkg::rd_t                         rd,
  output m3asm_pkg::tag_t                        tag
);

  typedef enum logic [1:0] {
    ST_LOAD  = 2'b01,
    ST_ISSUE = 2'b10
  } state_t;

  localparam logic [m3asm_pkg::CNT_W-1:0] CNT_LAST =
    m3asm_pkg::CNT_W'(2 * m3asm_pkg::CELLS - 1);
  localparam logic [m3asm_pkg::CNT_W-1:0] CNT_B =
    m3asm_pkg::CNT_W'(m3asm_pkg::CELLS);
  localparam logic [m3asm_pkg::DIM_W-1:0] IDX_MAX =
    m3asm_pkg::DIM_W'(m3asm_pkg::DIM - 1);

  state_t                         state;
  logic [m3asm_pkg::CNT_W-1:0]    load_count;
  m3asm_pkg::op_t                 held_op;
  m3asm_pkg::op_t                 run_op;
  m3asm_pkg::op_t                 eff_op;
  logic [m3asm_pkg::DIM_W-1:0]    r, c, k;
  logic                           accept;
  logic                           issue;
  logic                           k_done;
  logic                           entry_last;
  logic [m3asm_pkg::IDX_W-1:0]    cell_idx;

  // Matrix B occupies the upper half of the load count.
  assign in_ready = (state == ST_LOAD) && !pipe_busy;
  assign accept   = in_valid && in_ready;
  assign eff_op   = (load_count == '0) ? m3asm_pkg::op_t'(op) : held_op;

  always_comb begin
    wr.a_we = accept && (load_count < CNT_B);
    wr.b_we = accept && (load_count >= CNT_B);
    wr.addr = (load_count < CNT_B) ? m3asm_pkg::IDX_W'(load_count)
                                   : m3asm_pkg::IDX_W'(load_count - CNT_B);
    wr.data = value;
  end

  // Add and subtract need one operand pair per entry, multiply needs DIM.
  assign issue      = (state == ST_ISSUE) && advance;
  assign k_done     = (run_op != m3asm_pkg::OP_MUL) || (k == IDX_MAX);
  assign entry_last = (r == IDX_MAX) && (c == IDX_MAX);
  assign cell_idx   = m3asm_pkg::IDX_W'(r * m3asm_pkg::DIM)
                    + m3asm_pkg::IDX_W'(c);

  always_comb begin
    rd.re = issue;
    if (run_op == m3asm_pkg::OP_MUL) begin
      rd.a_addr = m3asm_pkg::IDX_W'(r * m3asm_pkg::DIM) + m3asm_pkg::IDX_W'(k);
      rd.b_addr = m3asm_pkg::IDX_W'(k * m3asm_pkg::DIM) + m3asm_pkg::IDX_W'(c);
    end else begin
      rd.a_addr = cell_idx;
      rd.b_addr = cell_idx;
    end
    tag.valid  = issue;
    tag.op     = run_op;
    tag.first  = (k == '0);
    tag.last_k = k_done;
    tag.row    = r;
    tag.col    = c;
    tag.last   = entry_last && k_done;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_LOAD;
      load_count <= '0;
      held_op    <= m3asm_pkg::OP_ADD;
      run_op     <= m3asm_pkg::OP_ADD;
      r          <= '0;
      c          <= '0;
      k          <= '0;
    end else begin
      unique case (state)
        ST_LOAD: begin
          if (accept) begin
            held_op <= eff_op;
            if (load_count == CNT_LAST) begin
              load_count <= '0;
              run_op     <= eff_op;
              r          <= '0;
              c          <= '0;
              k          <= '0;
              if (eff_op != m3asm_pkg::OP_NONE) begin
                state <= ST_ISSUE;
              end
            end else begin
              load_count <= load_count + 1'b1;
            end
          end
        end
        ST_ISSUE: begin
          if (issue) begin
            if (!k_done) begin
              k <= k + 1'b1;
            end else begin
              k <= '0;
              if (c != IDX_MAX) begin
                c <= c + 1'b1;
              end else begin
                c <= '0;
                if (r != IDX_MAX) begin
                  r <= r + 1'b1;
                end else begin
                  r     <= '0;
                  state <= ST_LOAD;
                end
              end
            end
          end
        end
        default: state <= ST_LOAD;
      endcase
    end
  end

endmodule
`default_nettype wire

// File: rtl/core/m3asm_alu.sv
`default_nettype none
module m3asm_alu (
  input  wire logic                                     clk,
  input  wire logic                                     rst,
  input  wire m3asm_pkg::tag_t                          tag,
  input  wire logic [m3asm_pkg::ELEM_WIDTH-1:0]         a_q,
  input  wire logic [m3asm_pkg::ELEM_WIDTH-1:0]         b_q,
  output logic                                          advance,
  output logic                                          pipe_busy,
  output logic                                          out_valid,
  input  wire logic                                     out_ready,
  output logic [m3asm_pkg::ROW_W-1:0]                   row,
  output logic [m3asm_pkg::ROW_W-1:0]                   col,
  output logic signed [m3asm_pkg::RES_W-1:0]            result,
  output logic                                          last
);

  m3asm_pkg::tag_t                          s1, s2;
  logic signed [m3asm_pkg::SUM_W-1:0]       sum;
  logic signed [m3asm_pkg::SUM_W-1:0]       diff;
  logic signed [m3asm_pkg::PROD_W-1:0]      prod;
  logic signed [m3asm_pkg::RES_W-1:0]       term;
  logic signed [m3asm_pkg::RES_W-1:0]       term_q;
  logic signed [m3asm_pkg::RES_W-1:0]       acc;
  logic signed [m3asm_pkg::RES_W-1:0]       acc_next;

  // The whole pipeline, memory read included, moves only when the output
  // register is free or being emptied.
  assign advance   = !out_valid || out_ready;
  assign pipe_busy = s1.valid || s2.valid;

  always_comb begin
    sum  = m3asm_pkg::SUM_W'(signed'(a_q)) + m3asm_pkg::SUM_W'(signed'(b_q));
    diff = m3asm_pkg::SUM_W'(signed'(a_q)) - m3asm_pkg::SUM_W'(signed'(b_q));
    prod = m3asm_pkg::PROD_W'(signed'(a_q)) * m3asm_pkg::PROD_W'(signed'(b_q));
    case (s1.op)
      m3asm_pkg::OP_ADD: term = m3asm_pkg::RES_W'(sum);
      m3asm_pkg::OP_SUB: term = m3asm_pkg::RES_W'(diff);
      default:           term = m3asm_pkg::RES_W'(prod);
    endcase
    acc_next = s2.first ? term_q : acc + term_q;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1.valid  <= 1'b0;
      s2.valid  <= 1'b0;
      out_valid <= 1'b0;
    end else if (advance) begin
      s1        <= tag;
      s2        <= s1;
      out_valid <= s2.valid && s2.last_k;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      term_q <= term;
      if (s2.valid) begin
        acc <= acc_next;
        if (s2.last_k) begin
          result <= acc_next;
          row    <= m3asm_pkg::ROW_W'(s2.row);
          col    <= m3asm_pkg::ROW_W'(s2.col);
          last   <= s2.last;
        end
      end
    end
  end

endmodule
`default_nettype wire

// File: rtl/core/matrix3_add_sub_mul.sv
`default_nettype none
// Channel   Direction  Handshake            Payload
// input     in         in_valid / in_ready  op, value
// output    out        out_valid/ out_ready row, col, result, last
//
// While a problem is loaded, each accepted input transaction writes one
// element; the eighteen elements of A and B go in one after another. The
// compute phase then reads one operand pair a cycle, while the pipeline
// advances, from the two element memories: nine pairs for add or subtract and
// twenty-seven for multiply. The pipeline drains before new input is taken.
// Reset clears the load counter, the sequencer and the pipeline valid bits.
// A stalled output holds the entire compute pipeline, memory reads included.
module matrix3_add_sub_mul (
  input  wire logic                                 clk,
  input  wire logic                                 rst,
  input  wire logic                                 in_valid,
  output logic                                      in_ready,
  input  wire logic [m3asm_pkg::OP_W-1:0]           op,
  input  wire logic signed [m3asm_pkg::ELEM_WIDTH-1:0] value,
  output logic                                      out_valid,
  input  wire logic                                 out_ready,
  output logic [m3asm_pkg::ROW_W-1:0]               row,
  output logic [m3asm_pkg::ROW_W-1:0]               col,
  output logic signed [m3asm_pkg::RES_W-1:0]        result,
  output logic                                      last
);

  m3asm_pkg::wr_t                      wr;
  m3asm_pkg::rd_t                      rd;
  m3asm_pkg::tag_t                     tag;
  logic                                advance;
  logic                                pipe_busy;
  logic [m3asm_pkg::ELEM_WIDTH-1:0]    a_q;
  logic [m3asm_pkg::ELEM_WIDTH-1:0]    b_q;

  // The sequencer counts loaded elements, latches the operation from the
  // first element of a problem and then walks the result entries.
  m3asm_seq u_seq (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .op        (op),
    .value     (value),
    .advance   (advance),
    .pipe_busy (pipe_busy),
    .wr        (wr),
    .rd        (rd),
    .tag       (tag)
  );

  // Matrix A store.
  m3asm_ram #(
    .WIDTH (m3asm_pkg::ELEM_WIDTH),
    .DEPTH (m3asm_pkg::CELLS)
  ) u_mat_a (
    .clk   (clk),
    .we    (wr.a_we),
    .waddr (wr.addr),
    .wdata (wr.data),
    .re    (rd.re),
    .raddr (rd.a_addr),
    .rdata (a_q)
  );

  // Matrix B store.
  m3asm_ram #(
    .WIDTH (m3asm_pkg::ELEM_WIDTH),
    .DEPTH (m3asm_pkg::CELLS)
  ) u_mat_b (
    .clk   (clk),
    .we    (wr.b_we),
    .waddr (wr.addr),
    .wdata (wr.data),
    .re    (rd.re),
    .raddr (rd.b_addr),
    .rdata (b_q)
  );

  // Arithmetic pipeline: operand term, then accumulation into the output
  // register.
  m3asm_alu u_alu (
    .clk       (clk),
    .rst       (rst),
    .tag       (tag),
    .a_q       (a_q),
    .b_q       (b_q),
    .advance   (advance),
    .pipe_busy (pipe_busy),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .row       (row),
    .col       (col),
    .result    (result),
    .last      (last)
  );

  // Loading and reading never share a cycle, so no forwarding is needed.
  a_no_rw_overlap: assert property (@(posedge clk) disable iff (rst)
    !((wr.a_we || wr.b_we) && rd.re))
    else $error("element store written while compute reads are issued");

  // No new transaction enters while compute work is still in flight.
  a_no_load_in_flight: assert property (@(posedge clk) disable iff (rst)
    (pipe_busy || rd.re) |-> !in_ready)
    else $error("input ready while compute pipeline is busy");

  // The final entry of a problem sits in the bottom right corner.
  a_last_corner: assert property (@(posedge clk) disable iff (rst)
    (out_valid && last) |->
      (row == m3asm_pkg::ROW_W'(m3asm_pkg::DIM - 1)) &&
      (col == m3asm_pkg::ROW_W'(m3asm_pkg::DIM - 1)))
    else $error("last flag on an entry other than the final one");

endmodule
`default_nettype wire
